/* rtl/gfba_pkg.sv */
// Shared constants, codes and types of the grouped free block allocator.
package gfba_pkg;

   // Geometry of the in-core free group and of block numbers.
   localparam int GROUP_SIZE = 100;
   localparam int BLOCK_BITS = 24;
   localparam int FILL_BITS  = 24;
   localparam int IDX_BITS   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int COUNT_BITS = $clog2(GROUP_SIZE + 1);

   localparam logic [COUNT_BITS-1:0] GROUP_COUNT = COUNT_BITS'(GROUP_SIZE);

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_FILL  = 2'd2,
      OP_SPILL = 2'd3
   } op_type;

   // Response status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_BUSY    = 2'd2;

   // Pending transfer codes.
   localparam logic [1:0] XFER_NONE  = 2'd0;
   localparam logic [1:0] XFER_FILL  = 2'd1;
   localparam logic [1:0] XFER_SPILL = 2'd2;

   // One write to the free stack memory.
   typedef struct packed {
      logic                  en;
      logic [IDX_BITS-1:0]   addr;
      logic [BLOCK_BITS-1:0] data;
   } mem_wr_type;

   // One response as produced by the controller.
   typedef struct packed {
      logic [1:0]            status;
      logic [BLOCK_BITS-1:0] block_out;
      logic [1:0]            transfer;
      logic [BLOCK_BITS-1:0] transfer_block;
      logic                  last_transfer_word;
      logic                  dirty;
   } rsp_type;

endpackage

/* rtl/gfba_stack_ram.sv */
// Free stack memory: one write port, one read port with registered read data.
module gfba_stack_ram (
   input  logic                             clock,
   input  gfba_pkg::mem_wr_type             wr,
   input  logic [gfba_pkg::IDX_BITS-1:0]    rd_addr,
   output logic [gfba_pkg::BLOCK_BITS-1:0]  rd_data
);
   import gfba_pkg::*;

   logic [BLOCK_BITS-1:0] mem [GROUP_SIZE];
   logic [BLOCK_BITS-1:0] rd_data_ff;

   // Write and synchronous read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gfba_ctrl.sv */
// Allocator controller: phase, count and transfer index, and the update of each request.
module gfba_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic [gfba_pkg::BLOCK_BITS-1:0]  req_free_block,
   input  logic [gfba_pkg::FILL_BITS-1:0]   req_fill_word,
   output gfba_pkg::mem_wr_type             mem_wr,
   output logic [gfba_pkg::IDX_BITS-1:0]    mem_rd_addr,
   input  logic [gfba_pkg::BLOCK_BITS-1:0]  mem_rd_data,
   output logic                             result_valid,
   output gfba_pkg::rsp_type                result
);
   import gfba_pkg::*;

   typedef enum logic [1:0] {
      PH_READY = 2'd0,
      PH_FILL  = 2'd1,
      PH_SPILL = 2'd2
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic [BLOCK_BITS-1:0] pending_ff, pending_in;
   logic                  modified_ff, modified_in;
   logic                  busy_ff, busy_in;

   op_type                op_ff;
   logic [BLOCK_BITS-1:0] fb_ff;
   logic [FILL_BITS-1:0]  fw_ff;

   logic                  accept;
   logic [COUNT_BITS-1:0] count_dec;
   logic [COUNT_BITS-1:0] count_eff;
   logic [COUNT_BITS-1:0] fill_count;

   assign accept    = start && !busy_ff;
   assign count_dec = count_ff - 1'b1;
   // A free on an empty stack first seeds the end marker, so it sees one entry.
   assign count_eff = (count_ff == '0) ? COUNT_BITS'(1) : count_ff;
   assign fill_count = (fw_ff > FILL_BITS'(GROUP_SIZE)) ? GROUP_COUNT
                                                        : COUNT_BITS'(fw_ff);

   // Read address is set up in the accept cycle; data returns while busy.
   assign mem_rd_addr = (req_op == OP_SPILL) ? IDX_BITS'(index_ff - 1'b1)
                                             : IDX_BITS'(count_dec);

   // Next state, memory write and response of the request in flight.
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      index_in    = index_ff;
      pending_in  = pending_ff;
      modified_in = modified_ff;
      busy_in     = busy_ff;
      mem_wr      = '0;
      result      = '0;
      result.status = STATUS_BUSY;

      if (accept) begin
         busy_in = 1'b1;
         // The end-marker seed goes in now so the push can use the port later.
         if ((req_op == OP_FREE) && (phase_ff == PH_READY) && (count_ff == '0)) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = '0;
            mem_wr.data = '0;
         end
      end

      if (busy_ff) begin
         busy_in = 1'b0;
         case (op_ff)
            OP_ALLOC: begin
               if (phase_ff == PH_READY) begin
                  if (count_ff == '0) begin
                     result.status = STATUS_NOSPACE;
                  end else if (mem_rd_data == '0) begin
                     // Popped the end marker: the disk is full.
                     count_in      = '0;
                     result.status = STATUS_NOSPACE;
                  end else begin
                     count_in         = count_dec;
                     modified_in      = 1'b1;
                     result.status    = STATUS_OK;
                     result.block_out = mem_rd_data;
                     if (count_dec == '0) begin
                        phase_in        = PH_FILL;
                        index_in        = '0;
                        result.transfer = XFER_FILL;
                     end
                  end
               end
            end
            OP_FREE: begin
               if (phase_ff == PH_READY) begin
                  modified_in   = 1'b1;
                  result.status = STATUS_OK;
                  if (count_eff >= GROUP_COUNT) begin
                     pending_in            = fb_ff;
                     index_in              = '0;
                     phase_in              = PH_SPILL;
                     result.transfer       = XFER_SPILL;
                     result.transfer_block = fb_ff;
                  end else begin
                     mem_wr.en   = 1'b1;
                     mem_wr.addr = IDX_BITS'(count_eff);
                     mem_wr.data = fb_ff;
                     count_in    = count_eff + 1'b1;
                  end
               end
            end
            OP_FILL: begin
               if (phase_ff == PH_FILL) begin
                  result.status   = STATUS_OK;
                  result.transfer = XFER_FILL;
                  if (index_ff == '0) begin
                     count_in = fill_count;
                  end else begin
                     mem_wr.en   = 1'b1;
                     mem_wr.addr = IDX_BITS'(index_ff - 1'b1);
                     mem_wr.data = BLOCK_BITS'(fw_ff);
                  end
                  if (index_ff >= GROUP_COUNT) begin
                     result.last_transfer_word = 1'b1;
                     index_in = '0;
                     phase_in = PH_READY;
                  end else begin
                     index_in = index_ff + 1'b1;
                  end
               end
            end
            OP_SPILL: begin
               if (phase_ff == PH_SPILL) begin
                  result.status         = STATUS_OK;
                  result.transfer       = XFER_SPILL;
                  result.transfer_block = pending_ff;
                  result.block_out      = (index_ff == '0) ? BLOCK_BITS'(count_ff)
                                                           : mem_rd_data;
                  if (index_ff >= GROUP_COUNT) begin
                     // Group written out: the freed block starts a new stack.
                     result.last_transfer_word = 1'b1;
                     index_in    = '0;
                     mem_wr.en   = 1'b1;
                     mem_wr.addr = '0;
                     mem_wr.data = pending_ff;
                     count_in    = COUNT_BITS'(1);
                     phase_in    = PH_READY;
                  end else begin
                     index_in = index_ff + 1'b1;
                  end
               end
            end
            default: begin
               result.status = STATUS_BUSY;
            end
         endcase
      end

      result.dirty = modified_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FILL;
         count_ff    <= '0;
         index_ff    <= '0;
         pending_ff  <= '0;
         modified_ff <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         index_ff    <= index_in;
         pending_ff  <= pending_in;
         modified_ff <= modified_in;
         busy_ff     <= busy_in;
      end
   end

   // Request payload held for the execute cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_type'(req_op);
         fb_ff <= req_free_block;
         fw_ff <= req_fill_word;
      end
   end

   assign busy         = busy_ff;
   assign result_valid = busy_ff;

   // Every request finishes in the cycle after it is taken.
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("controller stayed busy for more than one cycle");

   // The stack count never exceeds the group.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= GROUP_COUNT)
      else $error("free count beyond group size");

   // The transfer index is cleared whenever the allocator is ready.
   a_index_ready: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READY) |-> (index_ff == '0))
      else $error("transfer index left over in ready phase");

   // An accept cycle writes memory only to seed the end marker at entry zero.
   a_seed_write: assert property (@(posedge clock) disable iff (reset)
      (accept && mem_wr.en) |-> (mem_wr.addr == '0 && mem_wr.data == '0))
      else $error("unexpected memory write in accept cycle");

endmodule

/* rtl/grouped_free_block_allocator.sv */
// Top level of the grouped free block allocator: controller, stack memory, response register.
//
//   channel   ports                                     handshake
//   request   req_op, req_free_block, req_fill_word     start / busy
//   response  rsp_status, rsp_block_out, rsp_transfer,  rsp_valid, one cycle
//             rsp_transfer_block, rsp_last_transfer_word, rsp_dirty
//
// Each request is taken in its accept cycle, which issues the stack memory
// read; the next cycle uses the read data, writes the memory where the
// request needs it and loads the response register; busy is high in that
// cycle only. The response appears in the cycle after busy and is shown
// for one cycle. Reset puts the allocator in the fill phase with an empty
// stack; the stack memory itself is not cleared. The receiver cannot stall responses.
module grouped_free_block_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic [gfba_pkg::BLOCK_BITS-1:0]  req_free_block,
   input  logic [gfba_pkg::FILL_BITS-1:0]   req_fill_word,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [gfba_pkg::BLOCK_BITS-1:0]  rsp_block_out,
   output logic [1:0]                       rsp_transfer,
   output logic [gfba_pkg::BLOCK_BITS-1:0]  rsp_transfer_block,
   output logic                             rsp_last_transfer_word,
   output logic                             rsp_dirty
);
   import gfba_pkg::*;

   mem_wr_type            mem_wr;
   logic [IDX_BITS-1:0]   mem_rd_addr;
   logic [BLOCK_BITS-1:0] mem_rd_data;
   logic                  result_valid;
   rsp_type               result;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   gfba_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_free_block (req_free_block),
      .req_fill_word  (req_fill_word),
      .mem_wr         (mem_wr),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .result_valid   (result_valid),
      .result         (result)
   );

   gfba_stack_ram u_stack (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result_valid;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_block_out          = rsp_ff.block_out;
   assign rsp_transfer           = rsp_ff.transfer;
   assign rsp_transfer_block     = rsp_ff.transfer_block;
   assign rsp_last_transfer_word = rsp_ff.last_transfer_word;
   assign rsp_dirty              = rsp_ff.dirty;

endmodule
